// ===== hdl/ihp_pkg.sv =====
// Shared types, widths and codes for the indexed min-heap.
package ihp_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int ID_W     = 10;
    localparam int ID_COUNT = 1 << ID_W;
    localparam int KEY_W    = 32;

    // Request types
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    // One heap slot
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } slot_t;

    // Position map entry: present bit and slot index
    typedef struct packed {
        logic              present;
        logic [ADDR_W-1:0] slot;
    } pos_t;

endpackage

// ===== hdl/ihp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/indexed_min_heap.sv =====
// Top level of the indexed min-heap: request sequencer, sift unit and storage.
//
// Indexed binary min-heap of up to 1024 ids with 32-bit keys. One request at a
// time: insert, update key or delete; each returns one result with status,
// root id/key, empty flag and count. A request passes through lookup, an
// optional climb toward the root and, for update and delete, an optional
// descent, then writes back and presents the result. The sift rate is set
// by the single read port of the slot memory, which is visited once per
// parent or child. After reset the block clears all 1024 entries of its
// position map and holds in_stall high meanwhile.
module indexed_min_heap (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [ihp_pkg::ID_W-1:0]  item_id,
    input  logic [ihp_pkg::KEY_W-1:0] item_key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [ihp_pkg::ID_W-1:0]  min_id,
    output logic [ihp_pkg::KEY_W-1:0] min_key,
    output logic                      is_empty,
    output logic [ihp_pkg::CNT_W-1:0] item_count
);
    import ihp_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOKUP = 4'd2;
    localparam logic [3:0] S_DELGET = 4'd3;
    localparam logic [3:0] S_UP     = 4'd4;
    localparam logic [3:0] S_UPCMP  = 4'd5;
    localparam logic [3:0] S_DOWN   = 4'd6;
    localparam logic [3:0] S_DOWNL  = 4'd7;
    localparam logic [3:0] S_DOWNR  = 4'd8;
    localparam logic [3:0] S_FINAL  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [1:0]        status_reg, status_next;
    logic              allow_down_reg, allow_down_next;
    logic              rvalid_reg, rvalid_next;
    logic [1:0]        req_reg, req_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    slot_t             cur_reg, cur_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    slot_t             left_reg, left_next;
    slot_t             root_reg;

    // Memory ports
    logic              slot_we;
    logic [ADDR_W-1:0] slot_waddr;
    slot_t             slot_wdata;
    logic [ADDR_W-1:0] slot_raddr;
    slot_t             slot_rdata;
    logic              map_we;
    logic [ID_W-1:0]   map_waddr;
    pos_t              map_wdata;
    logic [ID_W-1:0]   map_raddr;
    pos_t              map_rdata;

    // Tree index arithmetic
    logic [ADDR_W-1:0] parent_idx;
    logic [CNT_W-1:0]  left_idx;
    logic [CNT_W:0]    right_idx;
    logic              take_left;
    logic              take_right;

    ihp_ram #(.WIDTH($bits(slot_t)), .DEPTH(CAPACITY)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ihp_ram #(.WIDTH($bits(pos_t)), .DEPTH(ID_COUNT)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = {1'b0, left_idx} + (CNT_W+1)'(1);

    // Child selection: left wins only if strictly smaller, right only if
    // strictly smaller than the current best
    assign take_left  = left_reg.key < cur_reg.key;
    assign take_right = rvalid_reg &&
                        (slot_rdata.key < (take_left ? left_reg.key : cur_reg.key));

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        fill_next       = fill_reg;
        status_next     = status_reg;
        allow_down_next = allow_down_reg;
        rvalid_next     = rvalid_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        slot_we         = 1'b0;
        slot_waddr      = pos_reg;
        slot_wdata      = cur_reg;
        slot_raddr      = ADDR_W'(fill_reg - CNT_W'(1));
        map_we          = 1'b0;
        map_waddr       = cur_reg.id;
        map_wdata       = '{present: 1'b1, slot: pos_reg};
        map_raddr       = item_id;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg[ID_W-1:0];
                map_wdata = '{present: 1'b0, slot: '0};
                clr_next  = clr_reg + CNT_W'(1);
                if (clr_reg == CNT_W'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    id_next    = item_id;
                    key_next   = item_key;
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                status_next = ST_OK;
                state_next  = S_DONE;
                cur_next    = '{id: id_reg, key: key_reg};
                pos_next    = map_rdata.slot;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        allow_down_next = 1'b0;
                        if (map_rdata.present)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (fill_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            pos_next   = fill_reg[ADDR_W-1:0];
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_UP;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        allow_down_next = 1'b1;
                        if (!map_rdata.present)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            state_next = S_UP;
                        end
                    end
                    REQ_DELETE:
                    begin
                        allow_down_next = 1'b1;
                        if (!map_rdata.present)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            // mark absent; last slot is being read meanwhile
                            map_we    = 1'b1;
                            map_waddr = id_reg;
                            map_wdata = '{present: 1'b0, slot: '0};
                            fill_next = fill_reg - CNT_W'(1);
                            if (map_rdata.slot != ADDR_W'(fill_reg - CNT_W'(1)))
                            begin
                                state_next = S_DELGET;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_DELGET:
            begin
                cur_next   = slot_rdata;
                state_next = S_UP;
            end

            S_UP:
            begin
                slot_raddr = parent_idx;
                if (pos_reg == '0)
                begin
                    state_next = allow_down_reg ? S_DOWN : S_FINAL;
                end
                else
                begin
                    state_next = S_UPCMP;
                end
            end

            S_UPCMP:
            begin
                if (slot_rdata.key > cur_reg.key)
                begin
                    // parent moves down into the hole
                    slot_we         = 1'b1;
                    slot_wdata      = slot_rdata;
                    map_we          = 1'b1;
                    map_waddr       = slot_rdata.id;
                    pos_next        = parent_idx;
                    allow_down_next = 1'b0;
                    state_next      = S_UP;
                end
                else
                begin
                    state_next = allow_down_reg ? S_DOWN : S_FINAL;
                end
            end

            S_DOWN:
            begin
                slot_raddr = left_idx[ADDR_W-1:0];
                state_next = (left_idx < fill_reg) ? S_DOWNL : S_FINAL;
            end

            S_DOWNL:
            begin
                left_next   = slot_rdata;
                slot_raddr  = right_idx[ADDR_W-1:0];
                rvalid_next = right_idx < {1'b0, fill_reg};
                state_next  = S_DOWNR;
            end

            S_DOWNR:
            begin
                if (take_right)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    map_we     = 1'b1;
                    map_waddr  = slot_rdata.id;
                    pos_next   = right_idx[ADDR_W-1:0];
                    state_next = S_DOWN;
                end
                else if (take_left)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = left_reg;
                    map_we     = 1'b1;
                    map_waddr  = left_reg.id;
                    pos_next   = left_idx[ADDR_W-1:0];
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                slot_we    = 1'b1;
                map_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            fill_reg       <= '0;
            status_reg     <= ST_OK;
            allow_down_reg <= 1'b0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            fill_reg       <= fill_next;
            status_reg     <= status_next;
            allow_down_reg <= allow_down_next;
            rvalid_reg     <= rvalid_next;
        end
    end

    // Payload registers; root copy tracks every write to slot zero
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        id_reg   <= id_next;
        key_reg  <= key_next;
        cur_reg  <= cur_next;
        pos_reg  <= pos_next;
        left_reg <= left_next;
        if (slot_we && slot_waddr == '0)
        begin
            root_reg <= slot_wdata;
        end
    end

    // Result
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_DONE);
    assign status     = status_reg;
    assign is_empty   = (fill_reg == '0);
    assign min_id     = is_empty ? '0 : root_reg.id;
    assign min_key    = is_empty ? '0 : root_reg.key;
    assign item_count = fill_reg;

endmodule
